// ===== sv/gitr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gitr_pkg
// Shared types and constants for the in-degree-two graph trim block.
// ----------------------------------------------------------------------------
package gitr_pkg;

   // default sizes of the vertex and edge stores
   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_MAX_EDGES    = 8192;

   // fixed field widths
   localparam int VID_W = 10;   // vertex id in a request
   localparam int CNT_W = 11;   // vertex count, survivors, rounds

   localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 11'd1024;

   // request commands (carried on req_tuser)
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2
   } status_type;

   // top-level command sequencer
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_RUN,
      TOP_QUERY
   } top_state_type;

   // trim engine sequencer
   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_INIT,
      ENG_EDGE_ADDR,
      ENG_EDGE_DATA,
      ENG_EDGE_UPDATE,
      ENG_EVAL,
      ENG_DECIDE
   } eng_state_type;

   // run completion report from the engine
   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] survivors;
      logic [CNT_W-1:0] rounds;
   } run_result_type;

endpackage

// ===== sv/gitr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gitr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gitr_ram #(
   parameter int  WIDTH = 1,
   parameter int  DEPTH = 2,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gitr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gitr_engine
// Trim sequencer: owns the active-flag RAM (two banks, ping-pong between
// rounds) and the hit-counter RAM, and walks the edge store once per round.
// ----------------------------------------------------------------------------
module gitr_engine #(
   parameter int  MAX_VERTICES = gitr_pkg::DEF_MAX_VERTICES,
   parameter int  MAX_EDGES    = gitr_pkg::DEF_MAX_EDGES,
   localparam int VW           = $clog2(MAX_VERTICES),
   localparam int EW           = $clog2(MAX_EDGES + 1),
   localparam int EAW          = $clog2(MAX_EDGES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gitr_pkg::CNT_W-1:0]    vertex_num,
   input  logic [EW-1:0]                 edge_num,
   output logic                          edge_rd_en,
   output logic [EAW-1:0]                edge_rd_addr,
   input  logic [2*gitr_pkg::VID_W-1:0]  edge_rd_data,
   input  logic                          qry_en,
   input  logic [VW-1:0]                 qry_addr,
   output logic                          qry_flag,
   output gitr_pkg::run_result_type      result
);

   import gitr_pkg::*;

   // sequencer and counters
   eng_state_type    state_ff, state_in;
   logic [CNT_W-1:0] vcnt_ff, vcnt_in;
   logic [EW-1:0]    ecnt_ff, ecnt_in;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] next_cnt_ff, next_cnt_in;
   logic [CNT_W-1:0] rounds_ff, rounds_in;
   logic             pend_ff, pend_in;

   // per-edge and per-vertex payload
   logic [VW-1:0]    tgt_ff, tgt_in;
   logic             edge_ok_ff, edge_ok_in;
   logic [VW-1:0]    eaddr_ff, eaddr_in;

   // RAM ports
   logic             act_wr_en, act_rd_en, act_wr_data, act_rd_data;
   logic [VW:0]      act_wr_addr, act_rd_addr;
   logic             hit_wr_en, hit_rd_en;
   logic [VW-1:0]    hit_wr_addr, hit_rd_addr;
   logic [1:0]       hit_wr_data, hit_rd_data;

   logic [VID_W-1:0] e_src, e_tgt;

   assign e_src = edge_rd_data[VID_W-1:0];
   assign e_tgt = edge_rd_data[2*VID_W-1:VID_W];

   gitr_ram #(.WIDTH(1), .DEPTH(2 * MAX_VERTICES)) u_act_ram (
      .clock   (clock),
      .wr_en   (act_wr_en),
      .wr_addr (act_wr_addr),
      .wr_data (act_wr_data),
      .rd_en   (act_rd_en),
      .rd_addr (act_rd_addr),
      .rd_data (act_rd_data)
   );

   gitr_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_hit_ram (
      .clock   (clock),
      .wr_en   (hit_wr_en),
      .wr_addr (hit_wr_addr),
      .wr_data (hit_wr_data),
      .rd_en   (hit_rd_en),
      .rd_addr (hit_rd_addr),
      .rd_data (hit_rd_data)
   );

   assign qry_flag = act_rd_data;

   // next state and RAM control
   always_comb begin
      state_in    = state_ff;
      vcnt_in     = vcnt_ff;
      ecnt_in     = ecnt_ff;
      bank_in     = bank_ff;
      cur_in      = cur_ff;
      next_cnt_in = next_cnt_ff;
      rounds_in   = rounds_ff;
      pend_in     = 1'b0;
      tgt_in      = tgt_ff;
      edge_ok_in  = edge_ok_ff;
      eaddr_in    = eaddr_ff;

      edge_rd_en   = 1'b0;
      edge_rd_addr = EAW'(ecnt_ff);
      act_wr_en    = 1'b0;
      act_wr_addr  = {1'b0, VW'(vcnt_ff)};
      act_wr_data  = 1'b1;
      act_rd_en    = 1'b0;
      act_rd_addr  = {bank_ff, qry_addr};
      hit_wr_en    = 1'b0;
      hit_wr_addr  = VW'(vcnt_ff);
      hit_wr_data  = 2'd0;
      hit_rd_en    = 1'b0;
      hit_rd_addr  = VW'(vcnt_ff);

      result.done      = 1'b0;
      result.survivors = cur_ff;
      result.rounds    = rounds_ff + 1'b1;

      case (state_ff)
         ENG_IDLE: begin
            // final bank stays selected for queries
            act_rd_en = qry_en;
            if (start) begin
               vcnt_in  = '0;
               state_in = ENG_INIT;
            end
         end

         // mark every vertex active in bank 0 and zero its counter
         ENG_INIT: begin
            if (vcnt_ff < vertex_num) begin
               act_wr_en = 1'b1;
               hit_wr_en = 1'b1;
               vcnt_in   = vcnt_ff + 1'b1;
            end else begin
               bank_in   = 1'b0;
               cur_in    = vertex_num;
               rounds_in = '0;
               ecnt_in   = '0;
               state_in  = ENG_EDGE_ADDR;
            end
         end

         // fetch the next stored edge, or move on to evaluation
         ENG_EDGE_ADDR: begin
            if (ecnt_ff < edge_num) begin
               edge_rd_en = 1'b1;
               state_in   = ENG_EDGE_DATA;
            end else begin
               vcnt_in     = '0;
               next_cnt_in = '0;
               state_in    = ENG_EVAL;
            end
         end

         // look up source activity and target counter
         ENG_EDGE_DATA: begin
            act_rd_en   = 1'b1;
            act_rd_addr = {bank_ff, VW'(e_src)};
            hit_rd_en   = 1'b1;
            hit_rd_addr = VW'(e_tgt);
            tgt_in      = VW'(e_tgt);
            edge_ok_in  = ({1'b0, e_src} < vertex_num) && ({1'b0, e_tgt} < vertex_num);
            state_in    = ENG_EDGE_UPDATE;
         end

         // saturating increment; one edge in flight, so no overlap on a counter
         ENG_EDGE_UPDATE: begin
            hit_wr_addr = tgt_ff;
            hit_wr_data = hit_rd_data + 2'd1;
            hit_wr_en   = edge_ok_ff && act_rd_data && !hit_rd_data[1];
            ecnt_in     = ecnt_ff + 1'b1;
            state_in    = ENG_EDGE_ADDR;
         end

         // read counter v while settling v-1: next flag into other bank, counter zeroed
         ENG_EVAL: begin
            if (vcnt_ff < vertex_num) begin
               hit_rd_en = 1'b1;
               pend_in   = 1'b1;
               eaddr_in  = VW'(vcnt_ff);
               vcnt_in   = vcnt_ff + 1'b1;
            end
            if (pend_ff) begin
               act_wr_en   = 1'b1;
               act_wr_addr = {~bank_ff, eaddr_ff};
               act_wr_data = hit_rd_data[1];
               hit_wr_en   = 1'b1;
               hit_wr_addr = eaddr_ff;
               hit_wr_data = 2'd0;
               next_cnt_in = next_cnt_ff + CNT_W'(hit_rd_data[1]);
            end
            if (!pend_ff && !(vcnt_ff < vertex_num)) begin
               state_in = ENG_DECIDE;
            end
         end

         // stop when the set size holds, else swap banks and go again
         ENG_DECIDE: begin
            rounds_in = rounds_ff + 1'b1;
            if (next_cnt_ff == cur_ff) begin
               result.done = 1'b1;
               state_in    = ENG_IDLE;
            end else begin
               cur_in   = next_cnt_ff;
               bank_in  = ~bank_ff;
               ecnt_in  = '0;
               state_in = ENG_EDGE_ADDR;
            end
         end

         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_IDLE;
         vcnt_ff     <= '0;
         ecnt_ff     <= '0;
         bank_ff     <= 1'b0;
         cur_ff      <= '0;
         next_cnt_ff <= '0;
         rounds_ff   <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         vcnt_ff     <= vcnt_in;
         ecnt_ff     <= ecnt_in;
         bank_ff     <= bank_in;
         cur_ff      <= cur_in;
         next_cnt_ff <= next_cnt_in;
         rounds_ff   <= rounds_in;
         pend_ff     <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tgt_ff     <= tgt_in;
      edge_ok_ff <= edge_ok_in;
      eaddr_ff   <= eaddr_in;
   end

endmodule

// ===== sv/graph_in_degree_trim_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_in_degree_trim_top
// In-degree-two trim over a stored directed graph, stream interface.
// ----------------------------------------------------------------------------
// One request in, one response out. Load and clear answer from the idle state;
// a query also takes one RAM read of the active flags. A run, for n vertices
// in use and E stored edges, is an init sweep over the vertices, then per
// round a walk over the edge store (edge read, flag and counter read, counter
// write, one edge in flight) followed by leaving the walk, a sweep over the
// vertex counters at one vertex a cycle and its drain, and a decide step. The
// next request is taken once the previous one is done and its response slot
// is free or being drained. The vertex count register must be written only
// while no request is open; the block itself does not enforce it.
module graph_in_degree_trim_top #(
   parameter int MAX_VERTICES = gitr_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = gitr_pkg::DEF_MAX_EDGES
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata [9:0] source_vertex, [19:10] target_vertex, [23:20] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // request: tuser [1:0] command
   input  logic [1:0]  req_tuser,
   // response: tdata [1:0] status, [12:2] survivor_count, [23:13] round_count,
   //           [24] in_set, [31:25] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // vertex count register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   import gitr_pkg::*;

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int EAW = $clog2(MAX_EDGES);

   top_state_type    state_ff, state_in;
   logic [CNT_W-1:0] vcount_ff;
   logic [EW-1:0]    stored_ff, stored_in;
   logic [CNT_W-1:0] run_n_ff, run_n_in;
   logic [CNT_W-1:0] surv_ff, surv_in;
   logic [CNT_W-1:0] rounds_ff, rounds_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic             in_set_ff, in_set_in;
   logic             qry_ok_ff, qry_ok_in;

   logic [CNT_W-1:0] n_eff;
   logic [VID_W-1:0] src, dst;
   logic             src_ok, dst_ok, req_fire;
   cmd_type          cmd;

   logic             eng_start, qry_en, qry_flag;
   run_result_type   eng_result;
   logic             edge_wr_en, edge_rd_en;
   logic [EAW-1:0]   edge_rd_addr;
   logic [2*VID_W-1:0] edge_rd_data;

   assign src = req_tdata[VID_W-1:0];
   assign dst = req_tdata[2*VID_W-1:VID_W];
   assign cmd = cmd_type'(req_tuser);

   // count in use, capped at the vertex store size
   assign n_eff  = (32'(vcount_ff) < MAX_VERTICES) ? vcount_ff : CNT_W'(MAX_VERTICES);
   assign src_ok = {1'b0, src} < n_eff;
   assign dst_ok = {1'b0, dst} < n_eff;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == TOP_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, in_set_ff, rounds_ff, surv_ff, status_ff};

   // edge store: source in the low half, target in the high half
   gitr_ram #(.WIDTH(2 * VID_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (EAW'(stored_ff)),
      .wr_data ({dst, src}),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   gitr_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (eng_start),
      .vertex_num   (n_eff),
      .edge_num     (stored_ff),
      .edge_rd_en   (edge_rd_en),
      .edge_rd_addr (edge_rd_addr),
      .edge_rd_data (edge_rd_data),
      .qry_en       (qry_en),
      .qry_addr     (VW'(src)),
      .qry_flag     (qry_flag),
      .result       (eng_result)
   );

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      stored_in    = stored_ff;
      run_n_in     = run_n_ff;
      surv_in      = surv_ff;
      rounds_in    = rounds_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      in_set_in    = in_set_ff;
      qry_ok_in    = qry_ok_ff;
      eng_start    = 1'b0;
      qry_en       = 1'b0;
      edge_wr_en   = 1'b0;

      case (state_ff)
         TOP_IDLE: begin
            if (req_fire) begin
               in_set_in = 1'b0;
               status_in = STS_OK;
               case (cmd)
                  CMD_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (!src_ok || !dst_ok) begin
                        status_in = STS_RANGE;
                     end else if (stored_ff == EW'(MAX_EDGES)) begin
                        status_in = STS_FULL;
                     end else begin
                        edge_wr_en = 1'b1;
                        stored_in  = stored_ff + 1'b1;
                     end
                  end
                  CMD_RUN: begin
                     eng_start = 1'b1;
                     run_n_in  = n_eff;
                     state_in  = TOP_RUN;
                  end
                  CMD_QUERY: begin
                     // vertices at or above the last run's count were never active
                     qry_en    = 1'b1;
                     qry_ok_in = src_ok && ({1'b0, src} < run_n_ff);
                     if (!src_ok) begin
                        status_in = STS_RANGE;
                     end
                     state_in = TOP_QUERY;
                  end
                  CMD_CLEAR: begin
                     stored_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         TOP_RUN: begin
            if (eng_result.done) begin
               surv_in      = eng_result.survivors;
               rounds_in    = eng_result.rounds;
               rsp_valid_in = 1'b1;
               state_in     = TOP_IDLE;
            end
         end

         TOP_QUERY: begin
            in_set_in    = qry_ok_ff && qry_flag;
            rsp_valid_in = 1'b1;
            state_in     = TOP_IDLE;
         end

         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         vcount_ff    <= VERTEX_COUNT_RESET;
         stored_ff    <= '0;
         run_n_ff     <= '0;
         surv_ff      <= '0;
         rounds_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_data;
         end
         stored_ff    <= stored_in;
         run_n_ff     <= run_n_in;
         surv_ff      <= surv_in;
         rounds_ff    <= rounds_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      in_set_ff <= in_set_in;
      qry_ok_ff <= qry_ok_in;
   end

endmodule
